// ----- rtl/mof_pkg.sv -----
// Shared types and constants for the motif occurrence finder.
package mof_pkg;

  // Fixed field widths of the ports.
  localparam int SYM_W  = 8;
  localparam int MIDX_W = 6;
  localparam int POS_W  = 11;
  localparam int CFG_W  = 7;
  localparam int CMD_W  = 2;

  // Command codes carried with each input word.
  localparam logic [CMD_W-1:0] CMD_SEQ     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOTIF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Controller state: normal operation, or reloading the reversed motif row.
  typedef enum logic {
    ST_RUN,
    ST_LOAD
  } load_state_t;

  // Controls broadcast to every cell of the compare chain.
  typedef struct packed {
    logic shift;   // a sequence byte enters the window chain
    logic clear;   // restart: window bytes return to zero
    logic rshift;  // reload: motif row shifts one cell along
  } cell_ctl_t;

endpackage

// ----- rtl/mof_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module mof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mof_cell.sv -----
// One cell of the compare chain: a window byte, a motif byte and their match flag.
module mof_cell #(
  parameter int INDEX = 0,
  parameter int LEN_W = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mof_pkg::cell_ctl_t        ctl,
  input  logic                      r_we,
  input  logic [mof_pkg::SYM_W-1:0] din,
  input  logic [mof_pkg::SYM_W-1:0] w_prev,
  input  logic [mof_pkg::SYM_W-1:0] r_prev,
  input  logic [LEN_W-1:0]          len,
  output logic [mof_pkg::SYM_W-1:0] w,
  output logic [mof_pkg::SYM_W-1:0] r,
  output logic                      hit
);

  localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

  // Window byte: shifts in from the neighbor, cleared on restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else if (ctl.clear) begin
      w <= '0;
    end else if (ctl.shift) begin
      w <= w_prev;
    end
  end

  // Motif byte aligned to this window slot: reloaded by shifting, or written directly.
  always_ff @(posedge clk) begin
    if (ctl.rshift) begin
      r <= r_prev;
    end else if (r_we) begin
      r <= din;
    end
  end

  // Cells past the active length always agree.
  assign hit = (IDX >= len) || (w == r);

endmodule

// ----- rtl/motif_occurrence_finder.sv -----
// Top level of the motif occurrence finder: control, motif RAM and compare chain.
//
// Usage: every input word carries cmd, symbol and motif_index. A sequence byte
// (CMD_SEQ) enters the window; when the newest motif_length bytes equal the
// motif, one result word with the 1-based start position is produced. A motif
// write (CMD_MOTIF) stores symbol at motif_index; a restart (CMD_RESTART)
// clears the window and the position count. Neither produces a result.
// Sequence bytes beyond MAX_SEQ_LEN are dropped.
// Input and output use valid/stall; a word moves when valid is high and
// stall is low. The motif length is written through cfg_wr_en/cfg_wr_data.
// A result moves from the pending compare of its sequence byte into the output
// register. Throughput: one word per cycle while the output is taken and no
// reload runs; the chain compares every cell in parallel in the cycle after the
// byte shifts in. When the output stalls with a result waiting and another
// compare is pending, the input stalls until the output register frees.
// A length write reorders the motif row: the input stalls while the row is
// shifted in from the motif RAM, one byte per cycle.
// Reset clears the window, the count and the output, and sets the length to 1.
module motif_occurrence_finder #(
  parameter int MOTIF_MAX   = 64,
  parameter int MAX_SEQ_LEN = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sym_valid,
  output logic                       sym_stall,
  input  logic [mof_pkg::CMD_W-1:0]  cmd,
  input  logic [mof_pkg::SYM_W-1:0]  symbol,
  input  logic [mof_pkg::MIDX_W-1:0] motif_index,
  output logic                       match_valid,
  input  logic                       match_stall,
  output logic [mof_pkg::POS_W-1:0]  match_position,
  input  logic                       cfg_wr_en,
  input  logic [mof_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int LEN_W = $clog2(MOTIF_MAX + 1);
  localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1);
  localparam int AW    = (MOTIF_MAX > 1) ? $clog2(MOTIF_MAX) : 1;
  localparam int XW    = (LEN_W > mof_pkg::MIDX_W) ? LEN_W : mof_pkg::MIDX_W;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Registers and their next values.
  logic [LEN_W-1:0]           len;
  logic [CNT_W-1:0]           count;
  logic                       pend;
  mof_pkg::load_state_t       state;
  mof_pkg::load_state_t       state_next;
  logic [LEN_W-1:0]           rd_cnt;
  logic [LEN_W-1:0]           rd_cnt_next;
  logic                       rd_v;
  logic                       rd_v_next;

  // Handshake and decode.
  logic                       accept;
  logic                       out_free;
  logic                       seq_go;
  logic                       restart_go;
  logic                       motif_go;
  logic                       pend_next;
  logic [LEN_W-1:0]           len_next;

  // Motif write addressing.
  logic [XW-1:0]              midx_x;
  logic [XW-1:0]              len_x;
  logic [XW-1:0]              target;
  logic                       direct_wr;
  logic [MOTIF_MAX-1:0]       r_we;

  // Chain signals.
  mof_pkg::cell_ctl_t         ctl;
  logic [mof_pkg::SYM_W-1:0]  w_row [MOTIF_MAX];
  logic [mof_pkg::SYM_W-1:0]  r_row [MOTIF_MAX];
  logic [MOTIF_MAX-1:0]       hit;
  logic [mof_pkg::SYM_W-1:0]  ram_rdata;

  // Compare result.
  logic                       found;
  logic [CMP_W-1:0]           count_c;
  logic [CMP_W-1:0]           len_c;
  logic [CMP_W-1:0]           pos_full;
  logic [CMP_W+mof_pkg::POS_W-1:0] pos_ext;

  // Input handshake: hold off while reloading or while a result cannot leave.
  assign out_free  = !match_valid || !match_stall;
  assign sym_stall = (state == mof_pkg::ST_LOAD) || (pend && !out_free);
  assign accept    = sym_valid && !sym_stall;

  assign seq_go     = accept && (cmd == mof_pkg::CMD_SEQ) &&
                      (count != CNT_W'(MAX_SEQ_LEN));
  assign restart_go = accept && (cmd == mof_pkg::CMD_RESTART);
  assign midx_x     = XW'(motif_index);
  assign len_x      = XW'(len);
  assign motif_go   = accept && (cmd == mof_pkg::CMD_MOTIF) &&
                      (midx_x < XW'(MOTIF_MAX));

  // A motif byte inside the active length also lands in its aligned cell.
  assign target    = len_x - XW'(1) - midx_x;
  assign direct_wr = motif_go && (midx_x < len_x);

  // Effective length of a configuration write: zero counts as one, large values saturate.
  always_comb begin
    if (cfg_wr_data == '0) begin
      len_next = LEN_W'(1);
    end else if (32'(cfg_wr_data) > MOTIF_MAX) begin
      len_next = LEN_W'(MOTIF_MAX);
    end else begin
      len_next = LEN_W'(cfg_wr_data);
    end
  end

  // Length register, position count and pending compare flag.
  assign pend_next = seq_go || (pend && !out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= LEN_W'(1);
      count <= '0;
      pend  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len <= len_next;
      end
      if (restart_go) begin
        count <= '0;
      end else if (seq_go) begin
        count <= count + CNT_W'(1);
      end
      pend <= pend_next;
    end
  end

  // Reload state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mof_pkg::ST_RUN;
      rd_cnt <= '0;
      rd_v   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_cnt <= rd_cnt_next;
      rd_v   <= rd_v_next;
    end
  end

  // Reload sequencer: read motif bytes 0 .. len-1 and shift them down the row.
  always_comb begin
    state_next  = state;
    rd_cnt_next = rd_cnt;
    rd_v_next   = 1'b0;
    unique case (state)
      mof_pkg::ST_RUN: begin
        if (cfg_wr_en) begin
          state_next  = mof_pkg::ST_LOAD;
          rd_cnt_next = '0;
        end
      end
      mof_pkg::ST_LOAD: begin
        if (cfg_wr_en) begin
          rd_cnt_next = '0;
        end else if (rd_cnt != len) begin
          rd_cnt_next = rd_cnt + LEN_W'(1);
          rd_v_next   = 1'b1;
        end else if (!rd_v) begin
          state_next = mof_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = mof_pkg::ST_RUN;
      end
    endcase
  end

  // Motif store.
  mof_ram #(
    .WIDTH (mof_pkg::SYM_W),
    .DEPTH (MOTIF_MAX)
  ) u_motif_ram (
    .clk   (clk),
    .we    (motif_go),
    .waddr (midx_x[AW-1:0]),
    .wdata (symbol),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Chain controls.
  always_comb begin
    ctl.shift  = seq_go;
    ctl.clear  = restart_go;
    ctl.rshift = rd_v;
  end

  // Compare chain: window bytes enter at cell 0, motif bytes reload from the RAM.
  for (genvar j = 0; j < MOTIF_MAX; j++) begin : g_cell
    assign r_we[j] = direct_wr && (target == XW'(j));

    if (j == 0) begin : g_head
      mof_cell #(
        .INDEX (j),
        .LEN_W (LEN_W)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .r_we   (r_we[j]),
        .din    (symbol),
        .w_prev (symbol),
        .r_prev (ram_rdata),
        .len    (len),
        .w      (w_row[j]),
        .r      (r_row[j]),
        .hit    (hit[j])
      );
    end else begin : g_body
      mof_cell #(
        .INDEX (j),
        .LEN_W (LEN_W)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .r_we   (r_we[j]),
        .din    (symbol),
        .w_prev (w_row[j-1]),
        .r_prev (r_row[j-1]),
        .len    (len),
        .w      (w_row[j]),
        .r      (r_row[j]),
        .hit    (hit[j])
      );
    end
  end

  // Match decision and start position of the occurrence.
  assign count_c  = CMP_W'(count);
  assign len_c    = CMP_W'(len);
  assign found    = (&hit) && (count_c >= len_c);
  assign pos_full = count_c - len_c + CMP_W'(1);
  assign pos_ext  = {{mof_pkg::POS_W{1'b0}}, pos_full};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (out_free) begin
      match_valid <= pend && found;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend && found) begin
      match_position <= pos_ext[mof_pkg::POS_W-1:0];
    end
  end

  // A new result appears only after a pending compare.
  a_result_from_compare: assert property (@(posedge clk) disable iff (rst)
    $rose(match_valid) |-> $past(pend))
    else $error("result word without a pending compare");

  // The position count never passes the sequence limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEQ_LEN))
    else $error("position count beyond sequence limit");

  // No input word is taken while the motif row reloads.
  a_stall_on_load: assert property (@(posedge clk) disable iff (rst)
    (state == mof_pkg::ST_LOAD) |-> sym_stall)
    else $error("input taken during motif reload");

  // A pending compare that cannot leave keeps the window frozen.
  a_hold_window: assert property (@(posedge clk) disable iff (rst)
    (pend && match_valid && match_stall) |=> $stable(count))
    else $error("window moved while a compare was blocked");

endmodule
